// File: src/cone_weighted_blur_2d_core_macros.svh
// Assertion macros for the cone-weighted blur core.
// Used by the port checker; no other dependencies.
`ifndef CONE_WEIGHTED_BLUR_2D_CORE_MACROS_SVH
`define CONE_WEIGHTED_BLUR_2D_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CWB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define CWB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/cwb_pkg.sv
// Shared constants, tables and types of the cone-weighted blur core.
// No dependencies.
`default_nettype none

package cwb_pkg;

   localparam int MaxRadius   = 10;
   localparam int Span        = 2 * MaxRadius;
   localparam int MaxWidth    = 1024;
   localparam int HeightLimit = 4096;

   localparam int RADIUS_W = 4;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 12;
   localparam int PIX_W    = 8;
   localparam int TAP_W    = 5;
   localparam int RING_W   = 5;
   localparam int ADDR_W   = RING_W + COL_W;
   localparam int WGT_W    = 5;
   localparam int TOTAL_W  = 14;
   localparam int ACC_W    = 22;
   localparam int QUO_W    = 8;
   localparam int DIST_W   = 8;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   // Control of the shared tap unit
   typedef struct packed {
      logic issue;
      logic clear;
      logic total_mode;
   } tap_ctrl_type;

   typedef logic [WGT_W-1:0] sqrt_tab_type [256];
   typedef logic [WGT_W-1:0] top_tab_type [16];

   // floor(sqrt(4*d)) for squared distance d
   function automatic sqrt_tab_type build_sqrt_tab();
      sqrt_tab_type t;
      int s;
      for (int d = 0; d < 256; d++) begin
         s = 0;
         while ((s + 1) * (s + 1) <= 4 * d) s++;
         t[d] = WGT_W'(s);
      end
      return t;
   endfunction

   // floor(sqrt(8*r*r)) for each legal radius
   function automatic top_tab_type build_top_tab();
      top_tab_type t;
      int s;
      for (int r = 0; r < 16; r++) begin
         s = 0;
         if (r <= MaxRadius) begin
            while ((s + 1) * (s + 1) <= 8 * r * r) s++;
         end
         t[r] = WGT_W'(s);
      end
      return t;
   endfunction

   localparam sqrt_tab_type SqrtTab = build_sqrt_tab();
   localparam top_tab_type  TopTab  = build_top_tab();

endpackage

`default_nettype wire

// File: src/cwb_line_store.sv
// Ring of source rows: one write port, one registered read port.
// Depends on cwb_pkg.
`default_nettype none

module cwb_line_store (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [cwb_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [cwb_pkg::PIX_W-1:0]  wr_data,
   input  wire logic [cwb_pkg::ADDR_W-1:0] rd_addr,
   output logic      [cwb_pkg::PIX_W-1:0]  rd_data
);

   logic [cwb_pkg::PIX_W-1:0] mem [0:cwb_pkg::Span*cwb_pkg::MaxWidth-1];
   logic [cwb_pkg::PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/cwb_tap_unit.sv
// Shared tap unit: cone weight of one tap, then multiply-accumulate.
// Depends on cwb_pkg.
`default_nettype none

module cwb_tap_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cwb_pkg::tap_ctrl_type        ctrl,
   input  wire logic [cwb_pkg::RADIUS_W-1:0] radius,
   input  wire logic [cwb_pkg::TAP_W-1:0]    tap_row,
   input  wire logic [cwb_pkg::TAP_W-1:0]    tap_col,
   input  wire logic [cwb_pkg::PIX_W-1:0]    pixel,
   output logic      [cwb_pkg::ACC_W-1:0]    acc
);

   logic signed [cwb_pkg::TAP_W:0]      d_row;
   logic signed [cwb_pkg::TAP_W:0]      d_col;
   logic [cwb_pkg::RADIUS_W-1:0]        a_row;
   logic [cwb_pkg::RADIUS_W-1:0]        a_col;
   logic [cwb_pkg::DIST_W-1:0]          dist2;
   logic [cwb_pkg::WGT_W-1:0]           weight;
   logic [cwb_pkg::WGT_W-1:0]           w_ff;
   logic                                vld_ff;
   logic                                mode_ff;
   logic [cwb_pkg::PIX_W+cwb_pkg::WGT_W-1:0] prod;
   logic [cwb_pkg::ACC_W-1:0]           addend;
   logic [cwb_pkg::ACC_W-1:0]           acc_ff;

   // offsets from the window center, magnitude only
   assign d_row = $signed({1'b0, tap_row}) - $signed({2'b00, radius});
   assign d_col = $signed({1'b0, tap_col}) - $signed({2'b00, radius});
   assign a_row = d_row[cwb_pkg::TAP_W] ? cwb_pkg::RADIUS_W'(-d_row)
                                        : d_row[cwb_pkg::RADIUS_W-1:0];
   assign a_col = d_col[cwb_pkg::TAP_W] ? cwb_pkg::RADIUS_W'(-d_col)
                                        : d_col[cwb_pkg::RADIUS_W-1:0];

   // squared distance and weight
   assign dist2  = cwb_pkg::DIST_W'(a_row * a_row) + cwb_pkg::DIST_W'(a_col * a_col);
   assign weight = cwb_pkg::TopTab[radius] - cwb_pkg::SqrtTab[dist2];

   // accumulate weight alone or weighted pixel
   assign prod   = cwb_pkg::PIX_W'(pixel) * (cwb_pkg::PIX_W+cwb_pkg::WGT_W)'(w_ff);
   assign addend = mode_ff ? cwb_pkg::ACC_W'(w_ff) : cwb_pkg::ACC_W'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         vld_ff <= ctrl.issue;
         if (ctrl.clear) begin
            acc_ff <= '0;
         end else if (vld_ff) begin
            acc_ff <= acc_ff + addend;
         end
      end
      w_ff    <= weight;
      mode_ff <= ctrl.total_mode;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// File: src/cwb_divider.sv
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on cwb_pkg.
`default_nettype none

module cwb_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [cwb_pkg::ACC_W-1:0]   dividend,
   input  wire logic [cwb_pkg::TOTAL_W-1:0] divisor,
   output logic                             done,
   output logic      [cwb_pkg::QUO_W-1:0]   quotient
);

   localparam int STEP_W = $clog2(cwb_pkg::QUO_W);

   logic                        run_ff;
   logic                        done_ff;
   logic [STEP_W-1:0]           k_ff;
   logic [cwb_pkg::ACC_W-1:0]   rem_ff;
   logic [cwb_pkg::QUO_W-1:0]   q_ff;
   logic [cwb_pkg::ACC_W-1:0]   trial;
   logic                        fits;

   assign trial = cwb_pkg::ACC_W'(divisor) << k_ff;
   assign fits  = (rem_ff >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && k_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         rem_ff <= dividend;
         q_ff   <= '0;
         k_ff   <= STEP_W'(cwb_pkg::QUO_W - 1);
      end else if (run_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - trial;
         end
         q_ff <= {q_ff[cwb_pkg::QUO_W-2:0], fits};
         k_ff <= k_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: src/cone_weighted_blur_2d_core.sv
// Cone-weighted 2D blur over a streamed 8-bit image, one request at a time.
// A pixel that completes no window goes through the window test and back to idle.
// A pixel that completes a window is filtered by the single tap unit, which
// walks the 2r x 2r taps (r = radius) one per cycle, followed by the divider.
// The first pixel of a frame first runs the weight-total sweep on the same tap
// unit. Radius, width and height are sampled on the first pixel of each frame.
// Depends on cwb_pkg, cwb_line_store, cwb_tap_unit and cwb_divider.
`default_nettype none

module cone_weighted_blur_2d_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [cwb_pkg::PIX_W-1:0]       req_pixel,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [cwb_pkg::PIX_W-1:0]       rsp_filtered,
   output logic      [cwb_pkg::COL_W-1:0]       rsp_out_col,
   output logic      [cwb_pkg::ROW_W-1:0]       rsp_out_row,
   output logic                                 rsp_frame_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [cwb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [cwb_pkg::CSR_W-1:0]       csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_TOTAL, S_TFLUSH, S_TEST, S_MAC, S_MFLUSH, S_DSTART, S_DWAIT, S_OUT
   } state_type;

   localparam int N_W = cwb_pkg::TAP_W;

   state_type state_ff, state_in;

   logic [cwb_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [cwb_pkg::WIDTH_W-1:0]  width_ff, width_in;
   logic [cwb_pkg::HEIGHT_W-1:0] height_ff, height_in;
   logic [cwb_pkg::RADIUS_W-1:0] act_r_ff, act_r_in;
   logic [cwb_pkg::WIDTH_W-1:0]  act_w_ff, act_w_in;
   logic [cwb_pkg::HEIGHT_W-1:0] act_h_ff, act_h_in;
   logic [cwb_pkg::COL_W-1:0]    in_col_ff, in_col_in;
   logic [cwb_pkg::ROW_W-1:0]    in_row_ff, in_row_in;
   logic [cwb_pkg::RING_W-1:0]   ring_ff, ring_in;
   logic [cwb_pkg::COL_W-1:0]    cur_col_ff, cur_col_in;
   logic [cwb_pkg::ROW_W-1:0]    cur_row_ff, cur_row_in;
   logic [cwb_pkg::RING_W-1:0]   cur_ring_ff, cur_ring_in;
   logic                         start_ff, start_in;
   logic [cwb_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [cwb_pkg::TAP_W-1:0]    ti_ff, ti_in;
   logic [cwb_pkg::TAP_W-1:0]    tj_ff, tj_in;
   logic [cwb_pkg::RING_W-1:0]   rd_ring_ff, rd_ring_in;
   logic [cwb_pkg::COL_W-1:0]    c0_ff, c0_in;
   logic [cwb_pkg::ROW_W-1:0]    r0_ff, r0_in;
   logic                         last_ff, last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cwb_pkg::PIX_W-1:0]    rsp_filt_ff, rsp_filt_in;
   logic [cwb_pkg::COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [cwb_pkg::ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         accept;
   logic                         frame_start;
   logic [cwb_pkg::RADIUS_W-1:0] san_r;
   logic [cwb_pkg::WIDTH_W-1:0]  san_w;
   logic [cwb_pkg::HEIGHT_W-1:0] san_h;
   logic [cwb_pkg::WIDTH_W-1:0]  eff_w;
   logic [cwb_pkg::HEIGHT_W-1:0] eff_h;
   logic [cwb_pkg::WIDTH_W-1:0]  next_col;
   logic [cwb_pkg::HEIGHT_W-1:0] next_row;
   logic [N_W-1:0]               n_taps;
   logic [cwb_pkg::WIDTH_W-1:0]  col_p1;
   logic [cwb_pkg::HEIGHT_W-1:0] row_p1;
   logic                         win_ok;
   logic [cwb_pkg::RING_W:0]     base_raw;
   logic [cwb_pkg::RING_W-1:0]   base_ring;
   logic                         tap_last_col;
   logic                         tap_last;
   logic [cwb_pkg::RING_W-1:0]   rd_ring_next;

   cwb_pkg::tap_ctrl_type        tap_ctrl;
   logic [cwb_pkg::PIX_W-1:0]    rd_pixel;
   logic [cwb_pkg::ACC_W-1:0]    acc;
   logic                         div_start;
   logic                         div_done;
   logic [cwb_pkg::QUO_W-1:0]    quotient;
   logic [cwb_pkg::ADDR_W-1:0]   wr_addr;
   logic [cwb_pkg::ADDR_W-1:0]   rd_addr;
   logic [cwb_pkg::COL_W-1:0]    rd_col;

   assign accept      = req_valid && req_ready;
   assign frame_start = (in_col_ff == '0) && (in_row_ff == '0);

   // clamp the registers into their legal ranges
   always_comb begin
      if (radius_ff == '0) begin
         san_r = cwb_pkg::RADIUS_W'(1);
      end else if (radius_ff > cwb_pkg::RADIUS_W'(cwb_pkg::MaxRadius)) begin
         san_r = cwb_pkg::RADIUS_W'(cwb_pkg::MaxRadius);
      end else begin
         san_r = radius_ff;
      end
      if (width_ff == '0) begin
         san_w = cwb_pkg::WIDTH_W'(1);
      end else if (width_ff > cwb_pkg::WIDTH_W'(cwb_pkg::MaxWidth)) begin
         san_w = cwb_pkg::WIDTH_W'(cwb_pkg::MaxWidth);
      end else begin
         san_w = width_ff;
      end
      if (height_ff == '0) begin
         san_h = cwb_pkg::HEIGHT_W'(1);
      end else if (height_ff > cwb_pkg::HEIGHT_W'(cwb_pkg::HeightLimit)) begin
         san_h = cwb_pkg::HEIGHT_W'(cwb_pkg::HeightLimit);
      end else begin
         san_h = height_ff;
      end
   end

   assign eff_w    = frame_start ? san_w : act_w_ff;
   assign eff_h    = frame_start ? san_h : act_h_ff;
   assign next_col = cwb_pkg::WIDTH_W'(in_col_ff) + 1'b1;
   assign next_row = cwb_pkg::HEIGHT_W'(in_row_ff) + 1'b1;

   // window test on the pixel just stored
   assign n_taps = {act_r_ff, 1'b0};
   assign col_p1 = cwb_pkg::WIDTH_W'(cur_col_ff) + 1'b1;
   assign row_p1 = cwb_pkg::HEIGHT_W'(cur_row_ff) + 1'b1;
   assign win_ok = (col_p1 >= cwb_pkg::WIDTH_W'(n_taps))
                && (col_p1 + 1'b1 <= act_w_ff)
                && (row_p1 >= cwb_pkg::HEIGHT_W'(n_taps))
                && (row_p1 + 1'b1 <= act_h_ff);

   // first ring row of the window, modulo the ring length
   assign base_raw  = (cwb_pkg::RING_W+1)'(cur_ring_ff) + (cwb_pkg::RING_W+1)'(cwb_pkg::Span + 1)
                    - (cwb_pkg::RING_W+1)'(n_taps);
   assign base_ring = (base_raw >= (cwb_pkg::RING_W+1)'(cwb_pkg::Span))
                    ? cwb_pkg::RING_W'(base_raw - (cwb_pkg::RING_W+1)'(cwb_pkg::Span))
                    : base_raw[cwb_pkg::RING_W-1:0];

   // tap walk
   assign tap_last_col = (tj_ff == n_taps - 1'b1);
   assign tap_last     = tap_last_col && (ti_ff == n_taps - 1'b1);
   assign rd_ring_next = (rd_ring_ff == cwb_pkg::RING_W'(cwb_pkg::Span - 1))
                       ? '0 : rd_ring_ff + 1'b1;

   always_comb begin
      state_in    = state_ff;
      radius_in   = radius_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      act_r_in    = act_r_ff;
      act_w_in    = act_w_ff;
      act_h_in    = act_h_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      ring_in     = ring_ff;
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      cur_ring_in = cur_ring_ff;
      start_in    = start_ff;
      total_in    = total_ff;
      ti_in       = ti_ff;
      tj_in       = tj_ff;
      rd_ring_in  = rd_ring_ff;
      c0_in       = c0_ff;
      r0_in       = r0_ff;
      last_in     = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_filt_in = rsp_filt_ff;
      rsp_col_in  = rsp_col_ff;
      rsp_row_in  = rsp_row_ff;
      rsp_last_in = rsp_last_ff;
      tap_ctrl    = '0;
      div_start   = 1'b0;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cwb_pkg::CSR_RADIUS: radius_in = csr_data[cwb_pkg::RADIUS_W-1:0];
            cwb_pkg::CSR_WIDTH:  width_in  = csr_data[cwb_pkg::WIDTH_W-1:0];
            cwb_pkg::CSR_HEIGHT: height_in = csr_data[cwb_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            tap_ctrl.clear = 1'b1;
            if (accept) begin
               start_in    = frame_start;
               cur_col_in  = in_col_ff;
               cur_row_in  = in_row_ff;
               cur_ring_in = ring_ff;
               ti_in       = '0;
               tj_in       = '0;
               if (frame_start) begin
                  act_r_in = san_r;
                  act_w_in = san_w;
                  act_h_in = san_h;
                  state_in = S_TOTAL;
               end else begin
                  state_in = S_TEST;
               end
               // advance the input position
               if (next_col >= eff_w) begin
                  in_col_in = '0;
                  if (next_row >= eff_h) begin
                     in_row_in = '0;
                     ring_in   = '0;
                  end else begin
                     in_row_in = next_row[cwb_pkg::ROW_W-1:0];
                     ring_in   = (ring_ff == cwb_pkg::RING_W'(cwb_pkg::Span - 1))
                               ? '0 : ring_ff + 1'b1;
                  end
               end else begin
                  in_col_in = next_col[cwb_pkg::COL_W-1:0];
               end
            end
         end
         S_TOTAL: begin
            tap_ctrl.issue      = 1'b1;
            tap_ctrl.total_mode = 1'b1;
            if (tap_last_col) begin
               tj_in = '0;
               ti_in = ti_ff + 1'b1;
            end else begin
               tj_in = tj_ff + 1'b1;
            end
            if (tap_last) begin
               state_in = S_TFLUSH;
            end
         end
         S_TFLUSH: begin
            state_in = S_TEST;
         end
         S_TEST: begin
            tap_ctrl.clear = 1'b1;
            if (start_ff) begin
               total_in = acc[cwb_pkg::TOTAL_W-1:0];
            end
            ti_in      = '0;
            tj_in      = '0;
            rd_ring_in = base_ring;
            c0_in      = cwb_pkg::COL_W'(col_p1 - cwb_pkg::WIDTH_W'(n_taps));
            r0_in      = cwb_pkg::ROW_W'(row_p1 - cwb_pkg::HEIGHT_W'(n_taps));
            last_in    = (col_p1 + 1'b1 == act_w_ff) && (row_p1 + 1'b1 == act_h_ff);
            state_in   = win_ok ? S_MAC : S_IDLE;
         end
         S_MAC: begin
            tap_ctrl.issue = 1'b1;
            if (tap_last_col) begin
               tj_in      = '0;
               ti_in      = ti_ff + 1'b1;
               rd_ring_in = rd_ring_next;
            end else begin
               tj_in = tj_ff + 1'b1;
            end
            if (tap_last) begin
               state_in = S_MFLUSH;
            end
         end
         S_MFLUSH: begin
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = quotient;
               rsp_col_in   = c0_ff;
               rsp_row_in   = r0_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= cwb_pkg::RADIUS_W'(1);
         width_ff     <= cwb_pkg::WIDTH_W'(32);
         height_ff    <= cwb_pkg::HEIGHT_W'(32);
         act_r_ff     <= cwb_pkg::RADIUS_W'(1);
         act_w_ff     <= cwb_pkg::WIDTH_W'(32);
         act_h_ff     <= cwb_pkg::HEIGHT_W'(32);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         ring_ff      <= '0;
         start_ff     <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         act_r_ff     <= act_r_in;
         act_w_ff     <= act_w_in;
         act_h_ff     <= act_h_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         ring_ff      <= ring_in;
         start_ff     <= start_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_col_ff  <= cur_col_in;
      cur_row_ff  <= cur_row_in;
      cur_ring_ff <= cur_ring_in;
      ti_ff       <= ti_in;
      tj_ff       <= tj_in;
      rd_ring_ff  <= rd_ring_in;
      c0_ff       <= c0_in;
      r0_ff       <= r0_in;
      last_ff     <= last_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_last_ff <= rsp_last_in;
   end

   // row store addressing
   assign wr_addr = {ring_ff, in_col_ff};
   assign rd_col  = c0_ff + cwb_pkg::COL_W'(tj_ff);
   assign rd_addr = {rd_ring_ff, rd_col};

   cwb_line_store u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_pixel)
   );

   cwb_tap_unit u_tap (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (tap_ctrl),
      .radius  (act_r_ff),
      .tap_row (ti_ff),
      .tap_col (tj_ff),
      .pixel   (rd_pixel),
      .acc     (acc)
   );

   cwb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filtered   = rsp_filt_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

`default_nettype wire

// File: src/cwb_checker.sv
// Port-level checker for the blur core, bound to the top level.
// Depends on cwb_pkg and cone_weighted_blur_2d_core_macros.svh.
`default_nettype none
`include "cone_weighted_blur_2d_core_macros.svh"

module cwb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [cwb_pkg::PIX_W-1:0]     rsp_filtered,
   input wire logic [cwb_pkg::COL_W-1:0]     rsp_out_col,
   input wire logic [cwb_pkg::ROW_W-1:0]     rsp_out_row,
   input wire logic                          rsp_frame_last
);

   // a stalled response holds its payload
   `CWB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_filtered) && $stable(rsp_out_col) && $stable(rsp_out_row) && $stable(rsp_frame_last))

   // one request at a time: busy right after an accepted request
   `CWB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // a new response comes out as the core returns to ready
   `CWB_ASSERT_NOW(a_rsp_with_ready, clock, reset, $rose(rsp_valid), req_ready && !$past(req_ready))

   // an idle core has nothing queued behind a taken response
   `CWB_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_valid && rsp_ready && req_ready, !rsp_valid)

endmodule

bind cone_weighted_blur_2d_core cwb_checker u_chk (.*);

`default_nettype wire
